// ----- design/spnt_pkg.sv -----
package spnt_pkg;

    localparam int STRIPS_DEF   = 128;
    localparam int ADC_BITS_DEF = 10;

    localparam logic [15:0] CNT_MAX     = 16'hFFFF;
    localparam logic [15:0] MIN_SAMPLES = 16'd10;
    localparam logic [13:0] SAT14       = 14'h3FFF;

    localparam logic [15:0] CAL_EVENTS_RST = 16'd100;
    localparam logic [15:0] UPD_EVENTS_RST = 16'd100;
    localparam logic [7:0]  CUT_RST        = 8'd48;

    typedef enum logic [1:0] {
        CFG_CALIBRATE_EVENTS = 2'd0,
        CFG_UPDATE_EVENTS    = 2'd1,
        CFG_SIGNAL_CUT       = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIVP_GO,
        ST_DIVP,
        ST_DIVN_GO,
        ST_DIVN,
        ST_SQRT,
        ST_WB
    } state_t;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- design/spnt_if.sv -----
interface spnt_sample_if;
    logic       valid;
    logic       ready;
    logic [9:0] adc_sample;
    logic       event_end;

    modport source (output valid, output adc_sample, output event_end, input ready);
    modport sink (input valid, input adc_sample, input event_end, output ready);
endinterface

interface spnt_result_if;
    logic        valid;
    logic        ready;
    logic [6:0]  strip_number;
    logic [13:0] pedestal_value;
    logic [13:0] noise_value;
    logic        is_updating;
    logic        value_refreshed;
    logic        last_of_event;

    modport source (output valid, output strip_number, output pedestal_value,
                    output noise_value, output is_updating, output value_refreshed,
                    output last_of_event, input ready);
    modport sink (input valid, input strip_number, input pedestal_value,
                  input noise_value, input is_updating, input value_refreshed,
                  input last_of_event, output ready);
endinterface

// ----- design/spnt_mem.sv -----
module spnt_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/spnt_div.sv -----
// restoring divider, one quotient bit per cycle; needs dividend < divisor * 2^32
module spnt_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             dividend,
    input  logic [31:0]             divisor,
    output spnt_pkg::unit_stat_t    stat,
    output logic [31:0]             quotient
);
    import spnt_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        ge;

    always_comb
    begin
        trial    = {rem_reg, low_reg[31]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
        low_next = {low_reg[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            low_reg <= dividend[31:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = low_reg;

endmodule

// ----- design/spnt_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
module spnt_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             radicand,
    output spnt_pkg::unit_stat_t    stat,
    output logic [15:0]             root
);
    import spnt_pkg::*;

    logic [31:0] rad_reg;
    logic [19:0] rem_reg, rem_next;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [19:0] r2;
    logic [19:0] trial;
    logic        ge;

    always_comb
    begin
        r2       = {rem_reg[17:0], rad_reg[31:30]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = (r2 >= trial);
        rem_next = ge ? (r2 - trial) : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[14:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ----- design/strip_pedestal_noise_tracker_unit.sv -----
// Channel   Modport  Moves
// sample_ch sink     one strip's ADC sample and end-of-event flag
// result_ch source   strip index, pedestal, noise and status for that strip
// cfg_*     write    calibrate_events, update_events, signal_cut
//
// One item at a time: a plain strip goes through read, evaluate and write back.
// A recomputed strip also passes the multiply steps, the 32-step pedestal divide
// and, unless the noise saturates, the 32-step noise divide and 16-step square root.
// After reset a clearing pass zeroes the strip memory, with no transfers in.
// A stalled result holds in the output register; the next item is taken meanwhile.
module strip_pedestal_noise_tracker_unit #(
    parameter int STRIPS   = spnt_pkg::STRIPS_DEF,
    parameter int ADC_BITS = spnt_pkg::ADC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    spnt_sample_if.sink          sample_ch,
    spnt_result_if.source        result_ch,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import spnt_pkg::*;

    localparam int AW    = (STRIPS > 1) ? $clog2(STRIPS) : 1;
    localparam int KW    = (AW > 7) ? AW : 7;
    localparam int SUM_W = ADC_BITS + 16;
    localparam int SQ_W  = 2 * ADC_BITS + 16;
    localparam int ENT_W = 16 + SUM_W + SQ_W + 28;
    localparam int DW    = (ADC_BITS + 4 > 14) ? ADC_BITS + 4 : 14;
    localparam logic [AW-1:0] LAST_STRIP = AW'(STRIPS - 1);

    state_t state_reg, state_next;

    // configuration
    logic [15:0] cal_reg, upd_reg;
    logic [7:0]  cut_reg;

    // control state
    logic [AW-1:0] strip_reg;
    logic [15:0]   ec_reg, phase_reg;
    logic          mode_reg;
    logic [AW-1:0] clr_addr_reg;

    // item being worked on
    logic [ADC_BITS-1:0] a_reg;
    logic                last_reg;
    logic [15:0]         cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [13:0]         ped_reg, noise_reg;
    logic                refresh_reg, post_clr_reg, wend_reg, bessel_reg;
    logic [15:0]         p_reg;

    // arithmetic
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg, acc_reg, nss_reg, x_reg;
    logic [31:0] den_reg;
    logic        noise_sat;

    // memory
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata, mem_rdata;
    logic [15:0]      e_cnt;
    logic [SUM_W-1:0] e_sum;
    logic [SQ_W-1:0]  e_sq;
    logic [13:0]      e_ped, e_noise;

    // evaluation
    logic [16:0]      n_cal, p_val;
    logic [15:0]      upd_eff;
    logic             wend, clr, acc_en, acc_do, comp;
    logic [15:0]      base_cnt, new_cnt;
    logic [SUM_W-1:0] base_sum, new_sum;
    logic [SQ_W-1:0]  base_sq, new_sq;
    logic [DW-1:0]    d16, ped_ext, dabs;
    logic [31:0]      lhs, rhs;

    // divide / root
    logic        div_start, sqrt_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor, div_q;
    logic [15:0] sq_root;
    logic [16:0] root_rnd;
    unit_stat_t  div_stat, sqrt_stat;

    // output
    logic          ovalid_reg, out_go;
    logic [KW-1:0] k_ext;
    logic [15:0]   ec_next;
    logic          mode_next;
    logic [6:0]    o_strip_reg;
    logic [13:0]   o_ped_reg, o_noise_reg;
    logic          o_upd_reg, o_ref_reg, o_last_reg;

    assign {e_cnt, e_sum, e_sq, e_ped, e_noise} = mem_rdata;

    spnt_mem #(.DEPTH(STRIPS), .WIDTH(ENT_W)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (strip_reg),
        .rdata (mem_rdata)
    );

    spnt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    spnt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q),
        .stat     (sqrt_stat),
        .root     (sq_root)
    );

    // strip evaluation on the entry just read
    always_comb
    begin
        n_cal    = {1'b0, ec_reg} + 17'd1;
        p_val    = {1'b0, phase_reg} + 17'd1;
        upd_eff  = (upd_reg == 16'd0) ? 16'd1 : upd_reg;
        wend     = (p_val >= {1'b0, upd_eff});
        clr      = mode_reg ? (p_val == 17'd1) : (n_cal == 17'd1);
        base_cnt = clr ? '0 : e_cnt;
        base_sum = clr ? '0 : e_sum;
        base_sq  = clr ? '0 : e_sq;
        d16      = DW'({a_reg, 4'b0000});
        ped_ext  = DW'(e_ped);
        dabs     = (d16 >= ped_ext) ? (d16 - ped_ext) : (ped_ext - d16);
        lhs      = 32'({dabs, 4'b0000});
        rhs      = 32'(cut_reg) * 32'(e_noise);
        acc_en   = mode_reg ? (lhs < rhs) : (n_cal <= {1'b0, cal_reg});
        acc_do   = acc_en && (base_cnt != CNT_MAX);
        new_cnt  = acc_do ? base_cnt + 16'd1 : base_cnt;
        new_sum  = acc_do ? base_sum + SUM_W'(a_reg) : base_sum;
        new_sq   = acc_do ? base_sq + SQ_W'(SQ_W'(a_reg) * SQ_W'(a_reg)) : base_sq;
        comp     = mode_reg ? (wend && (new_cnt > MIN_SAMPLES) && (new_sum != '0))
                            : (n_cal == {1'b0, cal_reg});
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 32'(cnt_reg);
        mul_b = '0;
        unique case (state_reg)
            ST_MUL0: mul_b = 32'(64'(sq_reg));
            ST_MUL1: mul_b = 32'(64'(sq_reg) >> 32);
            ST_MUL2:
            begin
                mul_a = 32'(sum_reg);
                mul_b = 32'(sum_reg);
            end
            ST_MUL3: mul_b = (bessel_reg && cnt_reg > 16'd1) ? 32'(cnt_reg - 16'd1)
                                                           : 32'(cnt_reg);
            default: mul_b = '0;
        endcase
    end

    always_comb
    begin
        noise_sat    = (x_reg >= (64'(den_reg) << 22));
        div_dividend = (state_reg == ST_DIVP_GO)
                       ? (64'({sum_reg, 5'b00000}) + 64'(cnt_reg)) : (x_reg << 10);
        div_divisor  = (state_reg == ST_DIVP_GO) ? 32'({cnt_reg, 1'b0}) : den_reg;
        div_start    = (state_reg == ST_DIVP_GO) || (state_reg == ST_DIVN_GO && !noise_sat);
        sqrt_start   = (state_reg == ST_DIVN) && div_stat.done;
        root_rnd     = (17'(sq_root) + 17'd1) >> 1;
    end

    // end-of-item control update, write back and clearing writes
    always_comb
    begin
        out_go    = !ovalid_reg || result_ch.ready;
        ec_next   = (ec_reg != CNT_MAX) ? ec_reg + 16'd1 : ec_reg;
        mode_next = mode_reg;
        if (last_reg && !mode_reg && ec_next >= cal_reg)
        begin
            mode_next = 1'b1;
        end
        k_ext     = KW'(strip_reg);
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB && out_go);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : strip_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0
                    : (post_clr_reg ? {16'd0, SUM_W'(0), SQ_W'(0), ped_reg, noise_reg}
                                    : {cnt_reg, sum_reg, sq_reg, ped_reg, noise_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_addr_reg == LAST_STRIP) state_next = ST_IDLE;
            ST_IDLE:    if (sample_ch.valid) state_next = ST_READ;
            ST_READ:    state_next = ST_EVAL;
            ST_EVAL:    state_next = (comp && new_cnt != 16'd0) ? ST_MUL0 : ST_WB;
            ST_MUL0:    state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_MUL3;
            ST_MUL3:    state_next = ST_DIVP_GO;
            ST_DIVP_GO: state_next = ST_DIVP;
            ST_DIVP:    if (div_stat.done) state_next = ST_DIVN_GO;
            ST_DIVN_GO: state_next = noise_sat ? ST_WB : ST_DIVN;
            ST_DIVN:    if (div_stat.done) state_next = ST_SQRT;
            ST_SQRT:    if (sqrt_stat.done) state_next = ST_WB;
            ST_WB:      if (out_go) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    assign sample_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cal_reg      <= CAL_EVENTS_RST;
            upd_reg      <= UPD_EVENTS_RST;
            cut_reg      <= CUT_RST;
            strip_reg    <= '0;
            ec_reg       <= '0;
            phase_reg    <= '0;
            mode_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_write)
            begin
                priority case (cfg_index)
                    CFG_CALIBRATE_EVENTS: cal_reg <= cfg_data;
                    CFG_UPDATE_EVENTS:    upd_reg <= cfg_data;
                    CFG_SIGNAL_CUT:       cut_reg <= cfg_data[7:0];
                    default:              ;
                endcase
            end
            if (state_reg == ST_WB && out_go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && result_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_WB && out_go)
            begin
                mode_reg   <= mode_next;
                if (last_reg)
                begin
                    ec_reg    <= ec_next;
                    strip_reg <= '0;
                    if (!mode_reg)
                    begin
                        if (mode_next)
                        begin
                            phase_reg <= '0;
                        end
                    end
                    else
                    begin
                        phase_reg <= wend_reg ? 16'd0 : p_reg;
                    end
                end
                else
                begin
                    strip_reg <= (strip_reg == LAST_STRIP) ? '0 : strip_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        unique case (state_reg)
            ST_IDLE:
            begin
                a_reg    <= ADC_BITS'(sample_ch.adc_sample);
                last_reg <= sample_ch.event_end;
            end
            ST_EVAL:
            begin
                cnt_reg      <= new_cnt;
                sum_reg      <= new_sum;
                sq_reg       <= new_sq;
                refresh_reg  <= comp;
                post_clr_reg <= mode_reg && wend;
                wend_reg     <= wend;
                p_reg        <= p_val[15:0];
                bessel_reg   <= !mode_reg;
                if (comp && new_cnt == 16'd0)
                begin
                    ped_reg   <= '0;
                    noise_reg <= '0;
                end
                else
                begin
                    ped_reg   <= e_ped;
                    noise_reg <= e_noise;
                end
            end
            ST_MUL1:    acc_reg <= prod_reg;
            ST_MUL2:    nss_reg <= acc_reg + (prod_reg << 32);
            ST_MUL3:    x_reg <= (nss_reg > prod_reg) ? (nss_reg - prod_reg) : '0;
            ST_DIVP_GO: den_reg <= prod_reg[31:0];
            ST_DIVP:
            begin
                if (div_stat.done)
                begin
                    ped_reg <= (div_q > 32'(SAT14)) ? SAT14 : div_q[13:0];
                end
            end
            ST_DIVN_GO:
            begin
                if (noise_sat)
                begin
                    noise_reg <= SAT14;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    noise_reg <= (root_rnd > 17'(SAT14)) ? SAT14 : root_rnd[13:0];
                end
            end
            ST_WB:
            begin
                if (out_go)
                begin
                    o_strip_reg <= k_ext[6:0];
                    o_ped_reg   <= ped_reg;
                    o_noise_reg <= noise_reg;
                    o_upd_reg   <= mode_next;
                    o_ref_reg   <= refresh_reg;
                    o_last_reg  <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign result_ch.valid           = ovalid_reg;
    assign result_ch.strip_number    = o_strip_reg;
    assign result_ch.pedestal_value  = o_ped_reg;
    assign result_ch.noise_value     = o_noise_reg;
    assign result_ch.is_updating     = o_upd_reg;
    assign result_ch.value_refreshed = o_ref_reg;
    assign result_ch.last_of_event   = o_last_reg;

    a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_WB))
        else $error("result raised outside write back");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_WB || state_reg == ST_CLEAR))
        else $error("strip memory written outside write back or clearing");

    a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |=> mode_reg)
        else $error("update mode left");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIVP || state_reg == ST_DIVN))
        else $error("divider busy outside a divide state");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.busy |-> (state_reg == ST_SQRT))
        else $error("square root busy outside its state");

endmodule
